// ===== sv/gcmgh_pkg.sv =====
`default_nettype none

package gcmgh_pkg;

    localparam int BLOCK_BITS  = 128;
    localparam int HALF_BITS   = 64;
    localparam int BLOCK_BYTES = 16;
    localparam int VBYTES_W    = 5;
    localparam int COUNT_BITS  = 61;
    localparam int DIGIT_BITS  = 8;
    localparam int CFG_IDX_W   = 2;

    // reflected reduction constant, 0xE1 followed by 120 zero bits
    localparam logic [BLOCK_BITS-1:0] RED_POLY = {8'hE1, 120'd0};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HASH_KEY_HIGH = 2'd0,
        REG_HASH_KEY_LOW  = 2'd1,
        REG_TAG_MASK_HIGH = 2'd2,
        REG_TAG_MASK_LOW  = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DATA,
        ST_LEN_GO,
        ST_LEN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

`default_nettype wire

// ===== sv/gcmgh_mult.sv =====
`default_nettype none

module gcmgh_mult #(
    parameter int DIGIT_BITS = gcmgh_pkg::DIGIT_BITS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [gcmgh_pkg::BLOCK_BITS-1:0] x_in,
    input  wire logic [gcmgh_pkg::BLOCK_BITS-1:0] h_in,
    output gcmgh_pkg::mul_stat_t                  stat,
    output logic      [gcmgh_pkg::BLOCK_BITS-1:0] z_out
);

    localparam int STEPS = gcmgh_pkg::BLOCK_BITS / DIGIT_BITS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

    logic [gcmgh_pkg::BLOCK_BITS-1:0] x_reg, x_next;
    logic [gcmgh_pkg::BLOCK_BITS-1:0] v_reg, v_next;
    logic [gcmgh_pkg::BLOCK_BITS-1:0] z_reg, z_next;
    logic [CNT_W-1:0]                 cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;

    // one digit of x per cycle, msb first
    always_comb begin
        z_next = z_reg;
        v_next = v_reg;
        for (int i = 0; i < DIGIT_BITS; i++) begin
            if (x_reg[gcmgh_pkg::BLOCK_BITS-1-i]) begin
                z_next = z_next ^ v_next;
            end
            v_next = {1'b0, v_next[gcmgh_pkg::BLOCK_BITS-1:1]}
                     ^ (v_next[0] ? gcmgh_pkg::RED_POLY : '0);
        end
        x_next = x_reg << DIGIT_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= x_in;
            v_reg <= h_in;
            z_reg <= '0;
        end else if (busy_reg) begin
            x_reg <= x_next;
            v_reg <= v_next;
            z_reg <= z_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign z_out     = z_reg;

endmodule

`default_nettype wire

// ===== sv/gcm_ghash_tag_engine.sv =====
`default_nettype none

// channel   ports                                             direction
// input     s_valid s_ready s_data_high s_data_low
//           s_valid_bytes s_is_additional s_final_item        in
// result    m_valid m_ready m_tag_high m_tag_low              out
// config    cfg_wr_en cfg_wr_idx cfg_wr_data                  in
//
// a block with valid bytes runs through the digit-serial multiplier (8 bits
// of x per cycle), then the engine returns to idle or, for a final item, goes on
// to the length block and then loads the tag
// an item with no valid bytes and no final flag is accepted without using the multiplier
// synchronous active-low reset clears accumulator, counts and config
// a final item waits in place while the result register still holds a tag
module gcm_ghash_tag_engine #(
    parameter int DIGIT_BITS = gcmgh_pkg::DIGIT_BITS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [gcmgh_pkg::HALF_BITS-1:0]  s_data_high,
    input  wire logic [gcmgh_pkg::HALF_BITS-1:0]  s_data_low,
    input  wire logic [gcmgh_pkg::VBYTES_W-1:0]   s_valid_bytes,
    input  wire logic                             s_is_additional,
    input  wire logic                             s_final_item,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [gcmgh_pkg::HALF_BITS-1:0]  m_tag_high,
    output logic      [gcmgh_pkg::HALF_BITS-1:0]  m_tag_low,
    input  wire logic                             cfg_wr_en,
    input  wire logic [gcmgh_pkg::CFG_IDX_W-1:0]  cfg_wr_idx,
    input  wire logic [gcmgh_pkg::HALF_BITS-1:0]  cfg_wr_data
);

    localparam int BB = gcmgh_pkg::BLOCK_BITS;
    localparam int HB = gcmgh_pkg::HALF_BITS;
    localparam int CB = gcmgh_pkg::COUNT_BITS;
    localparam int VW = gcmgh_pkg::VBYTES_W;

    gcmgh_pkg::state_t    state_reg, state_next;
    gcmgh_pkg::mul_stat_t mul_stat;

    logic [HB-1:0] key_hi_reg, key_lo_reg, mask_hi_reg, mask_lo_reg;
    logic [BB-1:0] acc_reg;
    logic [CB-1:0] aad_cnt_reg, aad_cnt_next;
    logic [CB-1:0] txt_cnt_reg, txt_cnt_next;
    logic          fin_reg;
    logic          m_valid_reg;
    logic [HB-1:0] tag_hi_reg, tag_lo_reg;

    logic [VW-1:0] n_clamp;
    logic [BB-1:0] byte_mask;
    logic [BB-1:0] mul_x;
    logic [BB-1:0] mul_z;
    logic [CB:0]   cnt_sum;
    logic [CB-1:0] cnt_sel;
    logic          accept;
    logic          mul_start;
    logic          emit_fire;

    assign n_clamp = (s_valid_bytes > VW'(gcmgh_pkg::BLOCK_BYTES))
                     ? VW'(gcmgh_pkg::BLOCK_BYTES) : s_valid_bytes;

    always_comb begin
        for (int k = 0; k < gcmgh_pkg::BLOCK_BYTES; k++) begin
            byte_mask[BB-1-8*k -: 8] = (VW'(k) < n_clamp) ? 8'hFF : 8'h00;
        end
    end

    // saturating byte count for the kind of data in this transfer
    assign cnt_sel = s_is_additional ? aad_cnt_reg : txt_cnt_reg;
    assign cnt_sum = {1'b0, cnt_sel} + (CB+1)'(n_clamp);

    always_comb begin
        aad_cnt_next = aad_cnt_reg;
        txt_cnt_next = txt_cnt_reg;
        if (s_is_additional) begin
            aad_cnt_next = cnt_sum[CB] ? '1 : cnt_sum[CB-1:0];
        end else begin
            txt_cnt_next = cnt_sum[CB] ? '1 : cnt_sum[CB-1:0];
        end
    end

    assign mul_x = (state_reg == gcmgh_pkg::ST_LEN_GO)
                   ? acc_reg ^ {aad_cnt_reg, 3'b000, txt_cnt_reg, 3'b000}
                   : acc_reg ^ ({s_data_high, s_data_low} & byte_mask);

    gcmgh_mult #(
        .DIGIT_BITS (DIGIT_BITS)
    ) u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .x_in    (mul_x),
        .h_in    ({key_hi_reg, key_lo_reg}),
        .stat    (mul_stat),
        .z_out   (mul_z)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gcmgh_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (n_clamp != '0) begin
                        state_next = gcmgh_pkg::ST_DATA;
                    end else if (s_final_item) begin
                        state_next = gcmgh_pkg::ST_LEN_GO;
                    end
                end
            end
            gcmgh_pkg::ST_DATA: begin
                if (mul_stat.done) begin
                    state_next = fin_reg ? gcmgh_pkg::ST_LEN_GO : gcmgh_pkg::ST_IDLE;
                end
            end
            gcmgh_pkg::ST_LEN_GO: begin
                state_next = gcmgh_pkg::ST_LEN;
            end
            gcmgh_pkg::ST_LEN: begin
                if (mul_stat.done) begin
                    state_next = gcmgh_pkg::ST_EMIT;
                end
            end
            gcmgh_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = gcmgh_pkg::ST_IDLE;
                end
            end
            default: state_next = gcmgh_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == gcmgh_pkg::ST_IDLE);
        accept    = s_ready && s_valid;
        mul_start = (accept && (n_clamp != '0)) || (state_reg == gcmgh_pkg::ST_LEN_GO);
        emit_fire = (state_reg == gcmgh_pkg::ST_EMIT) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gcmgh_pkg::ST_IDLE;
            key_hi_reg  <= '0;
            key_lo_reg  <= '0;
            mask_hi_reg <= '0;
            mask_lo_reg <= '0;
            acc_reg     <= '0;
            aad_cnt_reg <= '0;
            txt_cnt_reg <= '0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (gcmgh_pkg::cfg_reg_t'(cfg_wr_idx))
                    gcmgh_pkg::REG_HASH_KEY_HIGH: key_hi_reg  <= cfg_wr_data;
                    gcmgh_pkg::REG_HASH_KEY_LOW:  key_lo_reg  <= cfg_wr_data;
                    gcmgh_pkg::REG_TAG_MASK_HIGH: mask_hi_reg <= cfg_wr_data;
                    gcmgh_pkg::REG_TAG_MASK_LOW:  mask_lo_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (accept) begin
                fin_reg <= s_final_item;
                if (n_clamp != '0) begin
                    aad_cnt_reg <= aad_cnt_next;
                    txt_cnt_reg <= txt_cnt_next;
                end
            end
            if (mul_stat.done) begin
                acc_reg <= mul_z;
            end
            if (emit_fire) begin
                acc_reg     <= '0;
                aad_cnt_reg <= '0;
                txt_cnt_reg <= '0;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            tag_hi_reg <= acc_reg[BB-1:HB] ^ mask_hi_reg;
            tag_lo_reg <= acc_reg[HB-1:0] ^ mask_lo_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_tag_high = tag_hi_reg;
    assign m_tag_low  = tag_lo_reg;

endmodule

`default_nettype wire

// ===== sv/gcmgh_checker.sv =====
`default_nettype none

module gcmgh_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [4:0]  s_valid_bytes,
    input wire logic        s_final_item,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [63:0] m_tag_high,
    input wire logic [63:0] m_tag_low
);

    // a waiting tag holds
    a_tag_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tag_high) && $stable(m_tag_low))
        else $error("tag changed while stalled");

    // a block with data occupies the multiplier
    a_busy_after_data: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_valid_bytes != 5'd0) |=> !s_ready)
        else $error("input ready right after a data transfer");

    // an empty final transfer still runs the length block
    a_busy_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_final_item |=> !s_ready)
        else $error("input ready right after a final transfer");

    // an empty non-final transfer changes nothing
    a_empty_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_valid_bytes == 5'd0) && !s_final_item |=> s_ready)
        else $error("empty transfer stalled the input");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("tag valid after reset");

endmodule

bind gcm_ghash_tag_engine gcmgh_checker u_gcmgh_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_valid_bytes (s_valid_bytes),
    .s_final_item  (s_final_item),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_tag_high    (m_tag_high),
    .m_tag_low     (m_tag_low)
);

`default_nettype wire
